// ----- hw/rtl/cocol_pkg.sv -----
package cocol_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int MUL_LAT = 3;

   typedef logic signed [63:0] q_type;

   localparam q_type LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] LIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;

   localparam logic [2:0] CSR_CENTER_X    = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [2:0] CSR_OBST_RADIUS = 3'd2;
   localparam logic [2:0] CSR_OBST_ELAST  = 3'd3;
   localparam logic [2:0] CSR_TIME_STEP   = 3'd4;

   // radicand width of the root unit, rounded up to an even number of bits
   function automatic int sqrt_width(input int frac);
      return 64 + frac + (frac % 2);
   endfunction

   function automatic q_type sat65(input logic signed [64:0] s);
      q_type r;
      if (s > LIM65) begin
         r = LIM;
      end else if (s < -LIM65) begin
         r = -LIM;
      end else begin
         r = s[63:0];
      end
      return r;
   endfunction

   function automatic q_type sadd(input q_type a, input q_type b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      return sat65(s);
   endfunction

   function automatic q_type ssub(input q_type a, input q_type b);
      logic signed [64:0] s;
      s = 65'(a) - 65'(b);
      return sat65(s);
   endfunction

   function automatic logic [31:0] out32(input q_type v);
      logic [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/cocol_dly.sv -----
module cocol_dly #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            line_ff[i] <= '0;
         end
      end else if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

// ----- hw/rtl/cocol_mul.sv -----
module cocol_mul import cocol_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic  clock,
   input  logic  en,
   input  q_type op_a,
   input  q_type op_b,
   output q_type prod
);

   localparam logic [127:0] LIM_W = 128'(LIM);

   logic [63:0]  neg_a, neg_b, mag_a, mag_b;
   logic [63:0]  p00_in, p01_in, p10_in, p11_in;
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic         neg1_ff, neg2_ff;
   logic [127:0] full_in, full_ff, shift_w;
   q_type        sat_w, prod_ff;

   assign neg_a = -op_a;
   assign neg_b = -op_b;
   assign mag_a = op_a[63] ? neg_a : op_a;
   assign mag_b = op_b[63] ? neg_b : op_b;

   // four 32x32 partial products, summed in the next stage
   assign p00_in = mag_a[31:0]  * mag_b[31:0];
   assign p01_in = mag_a[31:0]  * mag_b[63:32];
   assign p10_in = mag_a[63:32] * mag_b[31:0];
   assign p11_in = mag_a[63:32] * mag_b[63:32];

   assign full_in = {64'b0, p00_ff} + ({64'b0, p01_ff} << 32) + ({64'b0, p10_ff} << 32)
                  + {p11_ff, 64'b0};

   assign shift_w = full_ff >> FRAC_BITS;
   assign sat_w   = (shift_w > LIM_W) ? LIM : q_type'(shift_w[63:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         neg1_ff <= op_a[63] ^ op_b[63];
         full_ff <= full_in;
         neg2_ff <= neg1_ff;
         prod_ff <= neg2_ff ? -sat_w : sat_w;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- hw/rtl/cocol_sqrt.sv -----
module cocol_sqrt import cocol_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic  clock,
   input  logic  en,
   input  q_type op,
   output q_type root
);

   localparam int NW = sqrt_width(FRAC_BITS);
   localparam int RW = NW / 2;

   logic [NW-1:0] rad_ff [RW+1];
   logic [RW+1:0] rem_ff [RW+1];
   logic [RW-1:0] rt_ff  [RW+1];

   // negative radicand reads as zero
   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0] <= op[63] ? '0 : (NW'(op[62:0]) << FRAC_BITS);
         rem_ff[0] <= '0;
         rt_ff[0]  <= '0;
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [RW+1:0] remsh, trial, rem_in;
      logic          ge;

      assign remsh  = {rem_ff[k][RW-1:0], rad_ff[k][NW-1 -: 2]};
      assign trial  = {rt_ff[k], 2'b01};
      assign ge     = remsh >= trial;
      assign rem_in = ge ? remsh - trial : remsh;

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k+1] <= rad_ff[k] << 2;
            rem_ff[k+1] <= rem_in;
            rt_ff[k+1]  <= {rt_ff[k][RW-2:0], ge};
         end
      end
   end

   assign root = q_type'(64'(rt_ff[RW]));

endmodule

// ----- hw/rtl/cocol_div.sv -----
module cocol_div import cocol_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic  clock,
   input  logic  en,
   input  q_type dvd,
   input  q_type dvs,
   output q_type quot
);

   localparam int NB = 63 + FRAC_BITS;
   localparam logic [NB-1:0] LIM_W = NB'(LIM);

   logic [63:0]   neg_a, neg_b;
   logic [62:0]   mag_a, mag_b;
   logic [NB-1:0] num_ff [NB+1];
   logic [63:0]   rem_ff [NB+1];
   logic [NB-1:0] q_ff   [NB+1];
   logic [62:0]   dv_ff  [NB+1];
   logic          neg_ff [NB+1];
   logic          bz_ff  [NB+1];
   q_type         qsat_w, quot_ff;

   assign neg_a = -dvd;
   assign neg_b = -dvs;
   assign mag_a = dvd[63] ? neg_a[62:0] : dvd[62:0];
   assign mag_b = dvs[63] ? neg_b[62:0] : dvs[62:0];

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= NB'(mag_a) << FRAC_BITS;
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
         dv_ff[0]  <= mag_b;
         neg_ff[0] <= dvd[63] ^ dvs[63];
         bz_ff[0]  <= (dvs == '0);
      end
   end

   for (genvar k = 0; k < NB; k++) begin : g_stage
      logic [63:0] remsh, rem_in;
      logic        ge;

      assign remsh  = {rem_ff[k][62:0], num_ff[k][NB-1]};
      assign ge     = remsh >= {1'b0, dv_ff[k]};
      assign rem_in = ge ? remsh - {1'b0, dv_ff[k]} : remsh;

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k+1] <= num_ff[k] << 1;
            rem_ff[k+1] <= rem_in;
            q_ff[k+1]   <= {q_ff[k][NB-2:0], ge};
            dv_ff[k+1]  <= dv_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            bz_ff[k+1]  <= bz_ff[k];
         end
      end
   end

   assign qsat_w = (q_ff[NB] > LIM_W) ? LIM : q_type'(q_ff[NB][63:0]);

   // divide by zero gives full scale with the dividend's sign
   always_ff @(posedge clock) begin
      if (en) begin
         if (bz_ff[NB]) begin
            quot_ff <= neg_ff[NB] ? -LIM : LIM;
         end else begin
            quot_ff <= neg_ff[NB] ? -qsat_w : qsat_w;
         end
      end
   end

   assign quot = quot_ff;

endmodule

// ----- hw/rtl/circle_obstacle_collision.sv -----
// channel  direction  handshake                  payload
// req      in         req_valid / req_ready      pos, vel, particle radius, elasticity
// rsp      out        rsp_valid / rsp_ready      new pos, new vel, contact
// csr      in         csr_we (no wait)           csr_index, csr_wdata
//
// One item per cycle while rsp is not stalled; the depth of the pipe is set
// mostly by two root units and two dividers that resolve one bit
// a stage. Each extra fractional bit adds about three stages.
// Reset is synchronous and clears the valid bits and the CSR registers to defaults.
// A stall on rsp freezes every stage at once; req_ready drops in the same cycle.
module circle_obstacle_collision import cocol_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic        [30:0] req_particle_radius,
   input  logic        [16:0] req_particle_elasticity,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_new_x,
   output logic signed [31:0] rsp_new_y,
   output logic signed [31:0] rsp_new_vx,
   output logic signed [31:0] rsp_new_vy,
   output logic               rsp_contact,
   input  logic               csr_we,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_wdata
);

   localparam int LAT_SQRT = sqrt_width(FRAC_BITS) / 2 + 1;
   localparam int LAT_DIV  = FRAC_BITS + 65;
   localparam q_type ONE_Q = q_type'(64'd1 << FRAC_BITS);

   typedef struct packed {
      q_type       px, py, vx, vy, pr, rs, rs2, d2, pr2, dx, dy;
      q_type       prx, pry, pdx, pdy, sp2, ts2, pd2, den, num, t;
      q_type       dlen, rsmd, nx, ny, rv, onee, pnx, pny;
      logic [16:0] pe;
      logic        fast, cond, contact, valid;
   } ctx_type;

   localparam int CW = $bits(ctx_type);

   logic signed [31:0] cx_ff, cy_ff;
   logic [30:0]        orad_ff, ts_ff;
   logic [16:0]        oel_ff;
   q_type              cx_q, cy_q, orad_q, ts_q;
   logic               advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff   <= '0;
         cy_ff   <= '0;
         orad_ff <= 31'd65536;
         oel_ff  <= 17'd65536;
         ts_ff   <= 31'd1092;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:    cx_ff   <= csr_wdata;
            CSR_CENTER_Y:    cy_ff   <= csr_wdata;
            CSR_OBST_RADIUS: orad_ff <= csr_wdata[30:0];
            CSR_OBST_ELAST:  oel_ff  <= csr_wdata[16:0];
            CSR_TIME_STEP:   ts_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign cx_q   = 64'(cx_ff);
   assign cy_q   = 64'(cy_ff);
   assign orad_q = q_type'({33'b0, orad_ff});
   assign ts_q   = q_type'({33'b0, ts_ff});

   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ---------------- stage 0: take the item
   ctx_type c0_in, c0_ff;
   always_comb begin
      c0_in       = '0;
      c0_in.valid = req_valid;
      c0_in.px    = 64'(req_pos_x);
      c0_in.py    = 64'(req_pos_y);
      c0_in.vx    = 64'(req_vel_x);
      c0_in.vy    = 64'(req_vel_y);
      c0_in.pr    = q_type'({33'b0, req_particle_radius});
      c0_in.pe    = req_particle_elasticity;
      c0_in.rs    = sadd(c0_in.pr, orad_q);
      c0_in.dx    = ssub(c0_in.px, cx_q);
      c0_in.dy    = ssub(c0_in.py, cy_q);
   end
   always_ff @(posedge clock) begin
      if (reset) c0_ff.valid <= 1'b0;
      else if (advance) c0_ff <= c0_in;
   end

   // ---------------- squares and v*dt
   q_type m_rs2, m_dx2, m_dy2, m_vx2, m_vy2, m_ts2, m_pr2, m_vxt, m_vyt;
   ctx_type c0d;
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_rs2 (.clock, .en(advance),
      .op_a(c0_ff.rs), .op_b(c0_ff.rs), .prod(m_rs2));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_dx2 (.clock, .en(advance),
      .op_a(c0_ff.dx), .op_b(c0_ff.dx), .prod(m_dx2));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_dy2 (.clock, .en(advance),
      .op_a(c0_ff.dy), .op_b(c0_ff.dy), .prod(m_dy2));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vx2 (.clock, .en(advance),
      .op_a(c0_ff.vx), .op_b(c0_ff.vx), .prod(m_vx2));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vy2 (.clock, .en(advance),
      .op_a(c0_ff.vy), .op_b(c0_ff.vy), .prod(m_vy2));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_ts2 (.clock, .en(advance),
      .op_a(ts_q), .op_b(ts_q), .prod(m_ts2));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_pr2 (.clock, .en(advance),
      .op_a(c0_ff.pr), .op_b(c0_ff.pr), .prod(m_pr2));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vxt (.clock, .en(advance),
      .op_a(c0_ff.vx), .op_b(ts_q), .prod(m_vxt));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vyt (.clock, .en(advance),
      .op_a(c0_ff.vy), .op_b(ts_q), .prod(m_vyt));
   cocol_dly #(.WIDTH(CW), .DEPTH(MUL_LAT)) u_d0 (.clock, .reset, .en(advance),
      .din(c0_ff), .dout(c0d));

   // ---------------- stage 1: sums, previous position
   ctx_type c1_in, c1_ff;
   always_comb begin
      c1_in     = c0d;
      c1_in.rs2 = m_rs2;
      c1_in.d2  = sadd(m_dx2, m_dy2);
      c1_in.pr2 = m_pr2;
      c1_in.sp2 = sadd(m_vx2, m_vy2);
      c1_in.ts2 = m_ts2;
      c1_in.prx = ssub(c0d.px, m_vxt);
      c1_in.pry = ssub(c0d.py, m_vyt);
      c1_in.pdx = ssub(c1_in.prx, cx_q);
      c1_in.pdy = ssub(c1_in.pry, cy_q);
   end
   always_ff @(posedge clock) begin
      if (reset) c1_ff.valid <= 1'b0;
      else if (advance) c1_ff <= c1_in;
   end

   q_type m_fl, m_pdx2, m_pdy2;
   ctx_type c1d;
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_fl (.clock, .en(advance),
      .op_a(c1_ff.sp2), .op_b(c1_ff.ts2), .prod(m_fl));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_pdx2 (.clock, .en(advance),
      .op_a(c1_ff.pdx), .op_b(c1_ff.pdx), .prod(m_pdx2));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_pdy2 (.clock, .en(advance),
      .op_a(c1_ff.pdy), .op_b(c1_ff.pdy), .prod(m_pdy2));
   cocol_dly #(.WIDTH(CW), .DEPTH(MUL_LAT)) u_d1 (.clock, .reset, .en(advance),
      .din(c1_ff), .dout(c1d));

   // ---------------- stage 2: fast test
   ctx_type c2_in, c2_ff;
   always_comb begin
      c2_in      = c1d;
      c2_in.fast = m_fl > c1d.pr2;
      c2_in.pd2  = sadd(m_pdx2, m_pdy2);
   end
   always_ff @(posedge clock) begin
      if (reset) c2_ff.valid <= 1'b0;
      else if (advance) c2_ff <= c2_in;
   end

   q_type s_pd, s_sd;
   ctx_type c2d;
   cocol_sqrt #(.FRAC_BITS(FRAC_BITS)) u_s_pd (.clock, .en(advance),
      .op(c2_ff.pd2), .root(s_pd));
   cocol_sqrt #(.FRAC_BITS(FRAC_BITS)) u_s_sd (.clock, .en(advance),
      .op(c2_ff.d2), .root(s_sd));
   cocol_dly #(.WIDTH(CW), .DEPTH(LAT_SQRT)) u_d2 (.clock, .reset, .en(advance),
      .din(c2_ff), .dout(c2d));

   // ---------------- stage 3: surface crossing test
   ctx_type c3_in, c3_ff;
   always_comb begin
      c3_in      = c2d;
      c3_in.cond = c2d.fast && (s_pd > c2d.rs) && (c2d.d2 <= c2d.rs2);
      c3_in.den  = ssub(s_pd, s_sd);
      c3_in.num  = ssub(s_pd, c2d.rs);
   end
   always_ff @(posedge clock) begin
      if (reset) c3_ff.valid <= 1'b0;
      else if (advance) c3_ff <= c3_in;
   end

   q_type v_t;
   ctx_type c3d;
   cocol_div #(.FRAC_BITS(FRAC_BITS)) u_v_t (.clock, .en(advance),
      .dvd(c3_ff.num), .dvs(c3_ff.den), .quot(v_t));
   cocol_dly #(.WIDTH(CW), .DEPTH(LAT_DIV)) u_d3 (.clock, .reset, .en(advance),
      .din(c3_ff), .dout(c3d));

   // ---------------- stage 4: clamp the crossing fraction
   ctx_type c4_in, c4_ff;
   q_type   t_w;
   always_comb begin
      t_w = (c3d.den > 0) ? v_t : ONE_Q;
      if (t_w < 0) t_w = '0;
      if (t_w > ONE_Q) t_w = ONE_Q;
      c4_in   = c3d;
      c4_in.t = t_w;
   end
   always_ff @(posedge clock) begin
      if (reset) c4_ff.valid <= 1'b0;
      else if (advance) c4_ff <= c4_in;
   end

   q_type m_vtx, m_vty, m_vtsx, m_vtsy;
   ctx_type c4d, c4dd;
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vtx (.clock, .en(advance),
      .op_a(c4_ff.vx), .op_b(c4_ff.t), .prod(m_vtx));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vty (.clock, .en(advance),
      .op_a(c4_ff.vy), .op_b(c4_ff.t), .prod(m_vty));
   cocol_dly #(.WIDTH(CW), .DEPTH(MUL_LAT)) u_d4 (.clock, .reset, .en(advance),
      .din(c4_ff), .dout(c4d));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vtsx (.clock, .en(advance),
      .op_a(m_vtx), .op_b(ts_q), .prod(m_vtsx));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_vtsy (.clock, .en(advance),
      .op_a(m_vty), .op_b(ts_q), .prod(m_vtsy));
   cocol_dly #(.WIDTH(CW), .DEPTH(MUL_LAT)) u_d4b (.clock, .reset, .en(advance),
      .din(c4d), .dout(c4dd));

   // ---------------- stage 5: move back to the entry point
   ctx_type c5_in, c5_ff;
   q_type   epx_w, epy_w;
   assign epx_w = sadd(c4dd.prx, m_vtsx);
   assign epy_w = sadd(c4dd.pry, m_vtsy);
   always_comb begin
      c5_in = c4dd;
      if (c4dd.cond) begin
         c5_in.px = epx_w;
         c5_in.py = epy_w;
         c5_in.dx = ssub(epx_w, cx_q);
         c5_in.dy = ssub(epy_w, cy_q);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) c5_ff.valid <= 1'b0;
      else if (advance) c5_ff <= c5_in;
   end

   q_type m_dx2b, m_dy2b;
   ctx_type c5d;
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_dx2b (.clock, .en(advance),
      .op_a(c5_ff.dx), .op_b(c5_ff.dx), .prod(m_dx2b));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_dy2b (.clock, .en(advance),
      .op_a(c5_ff.dy), .op_b(c5_ff.dy), .prod(m_dy2b));
   cocol_dly #(.WIDTH(CW), .DEPTH(MUL_LAT)) u_d5 (.clock, .reset, .en(advance),
      .din(c5_ff), .dout(c5d));

   // ---------------- stage 6: overlap test
   ctx_type c6_in, c6_ff;
   always_comb begin
      c6_in = c5d;
      if (c5d.cond) c6_in.d2 = sadd(m_dx2b, m_dy2b);
      c6_in.contact = c6_in.d2 < c5d.rs2;
   end
   always_ff @(posedge clock) begin
      if (reset) c6_ff.valid <= 1'b0;
      else if (advance) c6_ff <= c6_in;
   end

   q_type s_dist;
   ctx_type c6d;
   cocol_sqrt #(.FRAC_BITS(FRAC_BITS)) u_s_dist (.clock, .en(advance),
      .op(c6_ff.d2), .root(s_dist));
   cocol_dly #(.WIDTH(CW), .DEPTH(LAT_SQRT)) u_d6 (.clock, .reset, .en(advance),
      .din(c6_ff), .dout(c6d));

   // ---------------- stage 7: distance and penetration depth
   ctx_type c7_in, c7_ff;
   always_comb begin
      c7_in      = c6d;
      c7_in.dlen = s_dist;
      c7_in.rsmd = ssub(c6d.rs, s_dist);
   end
   always_ff @(posedge clock) begin
      if (reset) c7_ff.valid <= 1'b0;
      else if (advance) c7_ff <= c7_in;
   end

   q_type v_nx, v_ny;
   ctx_type c7d;
   cocol_div #(.FRAC_BITS(FRAC_BITS)) u_v_nx (.clock, .en(advance),
      .dvd(c7_ff.dx), .dvs(c7_ff.dlen), .quot(v_nx));
   cocol_div #(.FRAC_BITS(FRAC_BITS)) u_v_ny (.clock, .en(advance),
      .dvd(c7_ff.dy), .dvs(c7_ff.dlen), .quot(v_ny));
   cocol_dly #(.WIDTH(CW), .DEPTH(LAT_DIV)) u_d7 (.clock, .reset, .en(advance),
      .din(c7_ff), .dout(c7d));

   // ---------------- stage 8: normal, +x when centred
   ctx_type c8_in, c8_ff;
   always_comb begin
      c8_in = c7d;
      if (c7d.dlen == '0) begin
         c8_in.nx = ONE_Q;
         c8_in.ny = '0;
      end else begin
         c8_in.nx = v_nx;
         c8_in.ny = v_ny;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) c8_ff.valid <= 1'b0;
      else if (advance) c8_ff <= c8_in;
   end

   q_type m_rvx, m_rvy, m_pnx, m_pny;
   ctx_type c8d;
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_rvx (.clock, .en(advance),
      .op_a(c8_ff.vx), .op_b(c8_ff.nx), .prod(m_rvx));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_rvy (.clock, .en(advance),
      .op_a(c8_ff.vy), .op_b(c8_ff.ny), .prod(m_rvy));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_pnx (.clock, .en(advance),
      .op_a(c8_ff.nx), .op_b(c8_ff.rsmd), .prod(m_pnx));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_pny (.clock, .en(advance),
      .op_a(c8_ff.ny), .op_b(c8_ff.rsmd), .prod(m_pny));
   cocol_dly #(.WIDTH(CW), .DEPTH(MUL_LAT)) u_d8 (.clock, .reset, .en(advance),
      .din(c8_ff), .dout(c8d));

   // ---------------- stage 9: relative velocity, mean restitution
   ctx_type     c9_in, c9_ff;
   logic [17:0] esum_w;
   logic [16:0] eavg_w;
   q_type       e_w;
   assign esum_w = 18'(c8d.pe) + 18'(oel_ff);
   assign eavg_w = esum_w[17:1];
   assign e_w    = q_type'((64'(eavg_w) << FRAC_BITS) >> 16);
   always_comb begin
      c9_in      = c8d;
      c9_in.rv   = sadd(m_rvx, m_rvy);
      c9_in.onee = sadd(ONE_Q, e_w);
      c9_in.pnx  = m_pnx;
      c9_in.pny  = m_pny;
   end
   always_ff @(posedge clock) begin
      if (reset) c9_ff.valid <= 1'b0;
      else if (advance) c9_ff <= c9_in;
   end

   q_type m_imp, m_inx, m_iny;
   ctx_type c9d, c9dd;
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_imp (.clock, .en(advance),
      .op_a(c9_ff.onee), .op_b(c9_ff.rv), .prod(m_imp));
   cocol_dly #(.WIDTH(CW), .DEPTH(MUL_LAT)) u_d9 (.clock, .reset, .en(advance),
      .din(c9_ff), .dout(c9d));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_inx (.clock, .en(advance),
      .op_a(m_imp), .op_b(c9d.nx), .prod(m_inx));
   cocol_mul #(.FRAC_BITS(FRAC_BITS)) u_m_iny (.clock, .en(advance),
      .op_a(m_imp), .op_b(c9d.ny), .prod(m_iny));
   cocol_dly #(.WIDTH(CW), .DEPTH(MUL_LAT)) u_d9b (.clock, .reset, .en(advance),
      .din(c9d), .dout(c9dd));

   // ---------------- output register: reflect when approaching, push out
   logic        bounce_w;
   q_type       fvx_w, fvy_w, fpx_w, fpy_w;
   logic [31:0] new_x_ff, new_y_ff, new_vx_ff, new_vy_ff;
   logic        contact_ff;

   assign bounce_w = c9dd.contact && c9dd.rv[63];
   assign fvx_w    = bounce_w ? ssub(c9dd.vx, m_inx) : c9dd.vx;
   assign fvy_w    = bounce_w ? ssub(c9dd.vy, m_iny) : c9dd.vy;
   assign fpx_w    = c9dd.contact ? sadd(c9dd.px, c9dd.pnx) : c9dd.px;
   assign fpy_w    = c9dd.contact ? sadd(c9dd.py, c9dd.pny) : c9dd.py;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= c9dd.valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         new_x_ff   <= out32(fpx_w);
         new_y_ff   <= out32(fpy_w);
         new_vx_ff  <= out32(fvx_w);
         new_vy_ff  <= out32(fvy_w);
         contact_ff <= c9dd.contact;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_new_x   = new_x_ff;
   assign rsp_new_y   = new_y_ff;
   assign rsp_new_vx  = new_vx_ff;
   assign rsp_new_vy  = new_vy_ff;
   assign rsp_contact = contact_ff;

endmodule
